// ===== sv/xtea_pkg.sv =====
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned STAGES = 2 * ROUNDS;
  localparam logic [31:0] XTEA_DELTA = 32'h9E3779B9;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t key_t [4];

  typedef enum logic [CFG_IDX_W-1:0] {
    KEY_WORD_0 = 2'd0,
    KEY_WORD_1 = 2'd1,
    KEY_WORD_2 = 2'd2,
    KEY_WORD_3 = 2'd3
  } cfg_idx_t;

  // one item as it travels down the round pipeline
  typedef struct packed {
    logic  valid;
    logic  dec;
    word_t left;
    word_t right;
  } blk_t;

  // subkey of the first half-round of round r
  function automatic word_t subkey_even(input key_t k, input int unsigned r);
    word_t s;
    s = 32'(r) * XTEA_DELTA;
    return s + k[s[1:0]];
  endfunction

  // subkey of the second half-round of round r
  function automatic word_t subkey_odd(input key_t k, input int unsigned r);
    word_t s;
    s = 32'(r + 1) * XTEA_DELTA;
    return s + k[s[12:11]];
  endfunction

  function automatic word_t mix(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== sv/xtea_if.sv =====
`timescale 1ns / 1ps

interface xtea_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] left_word;
  logic [31:0] right_word;

  modport source (output valid, output req_type, output left_word, output right_word,
                  input ready);
  modport sink (input valid, input req_type, input left_word, input right_word,
                output ready);
endinterface

interface xtea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_result;
  logic [31:0] right_result;

  modport source (output valid, output left_result, output right_result, input ready);
  modport sink (input valid, input left_result, input right_result, output ready);
endinterface

// ===== sv/xtea_stage.sv =====
`timescale 1ns / 1ps

module xtea_stage
  import xtea_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  blk_t  d,
  input  word_t enc_key,
  input  word_t dec_key,
  input  logic  upd_left_enc,
  output blk_t  q
);

  logic  upd_left;
  word_t src;
  word_t f;
  word_t old_w;
  word_t new_w;

  // decryption walks the half-rounds backwards, so it updates the other half
  always_comb begin
    upd_left = upd_left_enc ^ d.dec;
    src      = upd_left ? d.right : d.left;
    old_w    = upd_left ? d.left : d.right;
    f        = mix(src) ^ (d.dec ? dec_key : enc_key);
    new_w    = d.dec ? (old_w - f) : (old_w + f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.dec   <= d.dec;
      q.left  <= upd_left ? new_w : d.left;
      q.right <= upd_left ? d.right : new_w;
    end
  end

endmodule

// ===== sv/xtea_out_q.sv =====
`timescale 1ns / 1ps

module xtea_out_q
  import xtea_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_left,
  input  word_t push_right,
  output logic  room,
  xtea_rsp_if.source rsp
);

  logic [1:0] count;
  logic [1:0] count_next;
  word_t      left0;
  word_t      right0;
  word_t      left1;
  word_t      right1;
  logic       pop;

  assign pop              = rsp.valid & rsp.ready;
  assign rsp.valid        = (count != 2'd0);
  assign rsp.left_result  = left0;
  assign rsp.right_result = right0;
  assign room             = (count != 2'd2);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        left0  <= push_left;
        right0 <= push_right;
      end else begin
        left0  <= left1;
        right0 <= right1;
        if (push) begin
          left1  <= push_left;
          right1 <= push_right;
        end
      end
    end else if (push) begin
      if (count == 2'd0) begin
        left0  <= push_left;
        right0 <= push_right;
      end else begin
        left1  <= push_left;
        right1 <= push_right;
      end
    end
  end

endmodule

// ===== sv/xtea_block_cipher_top.sv =====
`timescale 1ns / 1ps

// xtea cipher on 64-bit blocks with a 128-bit key, one item in and one item out
// per clock while the output queue has room. each of the 2*ROUNDS half-rounds
// has its own register stage; an item passes through them in order into the
// two-entry output queue and is offered on rsp once it is written there; with a
// ready consumer the result is taken at the next edge.
// encrypt and decrypt items may be mixed freely. the whole pipeline moves as one
// while the output queue has room, so a stalled consumer holds items in place;
// req.ready depends only on registered state. the key words are written through
// wr_en / wr_index / wr_data and must only change while no item is in flight.

module xtea_block_cipher_top
  import xtea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  word_t                wr_data,
  xtea_req_if.sink             req,
  xtea_rsp_if.source           rsp
);

  key_t key;
  logic advance;
  blk_t pipe [STAGES+1];

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= '0;
      key[1] <= '0;
      key[2] <= '0;
      key[3] <= '0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        KEY_WORD_0: key[0] <= wr_data;
        KEY_WORD_1: key[1] <= wr_data;
        KEY_WORD_2: key[2] <= wr_data;
        KEY_WORD_3: key[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // input enters stage 0 directly
  assign req.ready      = advance;
  assign pipe[0].valid  = req.valid;
  assign pipe[0].dec    = req.req_type;
  assign pipe[0].left   = req.left_word;
  assign pipe[0].right  = req.right_word;

  // one half-round per stage; encryption takes half-round j, decryption the
  // mirror half-round counted from the end
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam int unsigned ENC_R = j / 2;
    localparam int unsigned DEC_R = ROUNDS - 1 - j / 2;
    localparam bit          EVEN  = ((j % 2) == 0);

    word_t enc_key;
    word_t dec_key;

    assign enc_key = EVEN ? subkey_even(key, ENC_R) : subkey_odd(key, ENC_R);
    assign dec_key = EVEN ? subkey_odd(key, DEC_R) : subkey_even(key, DEC_R);

    xtea_stage u_stage (
      .clk          (clk),
      .rst          (rst),
      .en           (advance),
      .d            (pipe[j]),
      .enc_key      (enc_key),
      .dec_key      (dec_key),
      .upd_left_enc (EVEN),
      .q            (pipe[j+1])
    );
  end

  // output queue; pipeline moves only while it has a free entry
  xtea_out_q u_out_q (
    .clk        (clk),
    .rst        (rst),
    .push       (advance & pipe[STAGES].valid),
    .push_left  (pipe[STAGES].left),
    .push_right (pipe[STAGES].right),
    .room       (advance),
    .rsp        (rsp)
  );

endmodule
